FILE: rtl/gbs_pkg.sv
// Shared types, constants and helpers for greedy box suppression.
package gbs_pkg;

  localparam int COORD_W   = 16;
  localparam int LABEL_W   = 8;
  localparam int ORD_W     = 14;
  localparam int THR_W     = 16;
  localparam int AREA_W    = 2 * COORD_W;
  localparam int CORNERS_W = 4 * COORD_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam int MAX_KEPT_DEF   = 256;
  localparam int MAX_SET_DEF    = 16384;
  localparam int LABEL_BITS_DEF = 8;

  localparam logic [THR_W-1:0] IOU_THR_RESET = THR_W'(29491);

  localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_AGNOSTIC = CFG_IDX_W'(1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COORD_W-1:0]        span_t;
  typedef logic [AREA_W-1:0]         area_t;

  // Length of [lo, hi], zero when inverted.
  function automatic span_t span_of(input coord_t lo, input coord_t hi);
    logic signed [COORD_W:0] d;
    d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
    if (d[COORD_W] || d == '0) return '0;
    return d[COORD_W-1:0];
  endfunction

  function automatic coord_t cmax(input coord_t a, input coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t cmin(input coord_t a, input coord_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

FILE: rtl/gbs_box_if.sv
// Candidate box channel.
interface gbs_box_if import gbs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COORD_W-1:0]   left_edge;
  logic [COORD_W-1:0]   top_edge;
  logic [COORD_W-1:0]   right_edge;
  logic [COORD_W-1:0]   bottom_edge;
  logic [LABEL_W-1:0]   class_label;
  logic                 first_of_set;

  modport source (output valid, left_edge, top_edge, right_edge, bottom_edge,
                  class_label, first_of_set, input ready);
  modport sink   (input valid, left_edge, top_edge, right_edge, bottom_edge,
                  class_label, first_of_set, output ready);
endinterface

FILE: rtl/gbs_res_if.sv
// Suppression result channel.
interface gbs_res_if import gbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             keep;
  logic [ORD_W-1:0] box_ordinal;
  logic             list_full;

  modport source (output valid, keep, box_ordinal, list_full, input ready);
  modport sink   (input valid, keep, box_ordinal, list_full, output ready);
endinterface

FILE: rtl/gbs_cfg_if.sv
// Configuration write channel.
interface gbs_cfg_if import gbs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/greedy_box_suppression_core.sv
// Greedy box suppression: one box in, one keep/drop result out.
//
// Boxes arrive in falling score order; each is compared against every kept box of
// the current set, one kept-box memory read per cycle through a five-stage overlap
// pipeline. A new box is taken only once the last one is decided, and a decision
// waits while an earlier result is still held in the output register.
// A box is dropped when inter * 2^16 > iou_threshold * union for any kept box of
// the same class (any class when class_agnostic is set). Surviving boxes are stored
// while room remains; otherwise list_full is flagged. first_of_set empties the list
// and restarts the ordinal. The result register lets the next box be taken while a
// result is still waiting.
module greedy_box_suppression_core import gbs_pkg::*; #(
  parameter int MAX_KEPT   = MAX_KEPT_DEF,
  parameter int MAX_SET    = MAX_SET_DEF,
  parameter int LABEL_BITS = LABEL_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  gbs_box_if.sink     in_box,
  gbs_res_if.source   out_res,
  gbs_cfg_if.sink     cfg_wr
);

  localparam int COUNT_W = $clog2(MAX_KEPT + 1);
  localparam int ADDR_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int SET_W   = $clog2(MAX_SET);
  localparam int ENTRY_W = LABEL_BITS + AREA_W + CORNERS_W;
  localparam int UNI_W   = AREA_W + 1;
  localparam int PROD_W  = THR_W + UNI_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SPAN   = 3'd1;
  localparam logic [2:0] ST_AREA   = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic [THR_W-1:0] thr_r;
  logic             agnostic_r;

  coord_t                l_r, t_r, r_r, b_r;
  logic [LABEL_BITS-1:0] label_r;
  span_t                 w_r, h_r;
  area_t                 area_r;
  logic [COUNT_W-1:0]    count_r;
  logic [COUNT_W-1:0]    iss_r;
  logic [SET_W-1:0]      pos_r;
  logic [SET_W-1:0]      ord_r;
  logic                  suppress_r;

  logic [ENTRY_W-1:0] mem [MAX_KEPT];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [4:0]         v_r;

  logic                  s1_en_r;
  span_t                 s1_ix_r, s1_iy_r;
  area_t                 s1_karea_r;
  logic                  s2_en_r;
  area_t                 s2_inter_r, s2_karea_r;
  logic                  s3_en_r;
  logic [UNI_W-1:0]      s3_uni_r;
  area_t                 s3_inter_r;
  logic                  s4_en_r;
  logic [PROD_W-1:0]     s4_prod_r;
  area_t                 s4_inter_r;

  logic                  out_valid_r, out_keep_r, out_full_r;
  logic [ORD_W-1:0]      out_ord_r;

  logic                  in_fire, issue, scan_done, out_free, survive, room;
  logic [SET_W-1:0]      cur_pos;
  logic [LABEL_BITS-1:0] k_label;
  area_t                 k_area;
  coord_t                kl, kt, kr, kb;
  logic [PROD_W-1:0]     inter_sh;

  assign in_box.ready = (state_r == ST_IDLE);
  assign in_fire      = in_box.valid && in_box.ready;
  assign cfg_wr.ready = 1'b1;

  assign issue     = (state_r == ST_SCAN) && (iss_r < count_r);
  assign scan_done = (state_r == ST_SCAN) && (iss_r == count_r) && (v_r == '0);
  assign out_free  = !out_valid_r || out_res.ready;
  assign survive   = !suppress_r;
  assign room      = count_r < COUNT_W'(MAX_KEPT);
  assign cur_pos   = in_box.first_of_set ? '0 : pos_r;

  assign {k_label, k_area, kb, kr, kt, kl} = rd_data_r;
  assign inter_sh = PROD_W'(s4_inter_r) << 16;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_SPAN;
      ST_SPAN:   state_nxt = ST_AREA;
      ST_AREA:   state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_done) state_nxt = ST_DECIDE;
      ST_DECIDE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= IOU_THR_RESET;
      agnostic_r  <= 1'b0;
      count_r     <= '0;
      pos_r       <= '0;
      iss_r       <= '0;
      v_r         <= '0;
      suppress_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          REG_IOU_THRESHOLD:  thr_r <= cfg_wr.data[THR_W-1:0];
          REG_CLASS_AGNOSTIC: agnostic_r <= cfg_wr.data[0];
          default: ;
        endcase
      end

      if (in_fire) begin
        if (in_box.first_of_set) count_r <= '0;
        ord_r      <= cur_pos;
        pos_r      <= (cur_pos == SET_W'(MAX_SET - 1)) ? '0 : cur_pos + 1'b1;
        iss_r      <= '0;
        suppress_r <= 1'b0;
      end

      if (issue) iss_r <= iss_r + 1'b1;
      v_r <= {v_r[3:0], issue};

      if (v_r[4] && s4_en_r && (inter_sh > s4_prod_r)) suppress_r <= 1'b1;

      if (state_r == ST_DECIDE && out_free) begin
        out_valid_r <= 1'b1;
        out_ord_r   <= ORD_W'(ord_r);
        out_keep_r  <= survive && room;
        out_full_r  <= survive && !room;
        if (survive && room) count_r <= count_r + 1'b1;
      end else if (out_valid_r && out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Box capture, area and overlap pipeline
  always_ff @(posedge clk) begin
    if (in_fire) begin
      l_r     <= coord_t'(in_box.left_edge);
      t_r     <= coord_t'(in_box.top_edge);
      r_r     <= coord_t'(in_box.right_edge);
      b_r     <= coord_t'(in_box.bottom_edge);
      label_r <= LABEL_BITS'(in_box.class_label);
    end
    if (state_r == ST_SPAN) begin
      w_r <= span_of(l_r, r_r);
      h_r <= span_of(t_r, b_r);
    end
    if (state_r == ST_AREA) area_r <= w_r * h_r;

    s1_en_r    <= agnostic_r || (k_label == label_r);
    s1_ix_r    <= span_of(cmax(l_r, kl), cmin(r_r, kr));
    s1_iy_r    <= span_of(cmax(t_r, kt), cmin(b_r, kb));
    s1_karea_r <= k_area;

    s2_en_r    <= s1_en_r;
    s2_inter_r <= s1_ix_r * s1_iy_r;
    s2_karea_r <= s1_karea_r;

    s3_en_r    <= s2_en_r;
    s3_uni_r   <= UNI_W'(area_r) + UNI_W'(s2_karea_r) - UNI_W'(s2_inter_r);
    s3_inter_r <= s2_inter_r;

    s4_en_r    <= s3_en_r;
    s4_prod_r  <= PROD_W'(thr_r) * PROD_W'(s3_uni_r);
    s4_inter_r <= s3_inter_r;
  end

  // Kept-box memory
  always_ff @(posedge clk) begin
    if (issue) rd_data_r <= mem[iss_r[ADDR_W-1:0]];
    if (state_r == ST_DECIDE && out_free && survive && room) begin
      mem[count_r[ADDR_W-1:0]] <= {label_r, area_r, b_r, r_r, t_r, l_r};
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.keep        = out_keep_r;
  assign out_res.box_ordinal = out_ord_r;
  assign out_res.list_full   = out_full_r;

endmodule

FILE: tb/greedy_box_suppression_core_tb.sv
// Testbench for greedy_box_suppression_core: predicts each box's verdict, checks results.
`timescale 1ns / 100ps

module greedy_box_suppression_core_tb;
  import gbs_pkg::*;

  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int HOLD_CYCLES  = 600;
  localparam int RANDOM_ITEMS = 1080;
  localparam int FILL_ITEMS   = MAX_KEPT_DEF + 44;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [COORD_W-1:0] l;
    logic [COORD_W-1:0] t;
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] b;
    logic [LABEL_W-1:0] label;
    logic               first;
  } box_t;

  typedef struct packed {
    logic             keep;
    logic [ORD_W-1:0] ordinal;
    logic             full;
  } verdict_t;

  class keep_tracker;
    int                 kl[MAX_KEPT_DEF];
    int                 kt[MAX_KEPT_DEF];
    int                 kr[MAX_KEPT_DEF];
    int                 kb[MAX_KEPT_DEF];
    logic [LABEL_W-1:0] klab[MAX_KEPT_DEF];
    u64_t               karea[MAX_KEPT_DEF];
    int                 kept_n;
    int                 set_pos;
    int                 errors;
    logic [THR_W-1:0]   thr;
    bit                 agnostic;
    verdict_t           verdicts[$];

    function new();
      kept_n   = 0;
      set_pos  = 0;
      errors   = 0;
      thr      = IOU_THR_RESET;
      agnostic = 1'b0;
    endfunction

    function u64_t extent(int lo, int hi);
      return (hi > lo) ? u64_t'(hi - lo) : u64_t'(0);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        REG_IOU_THRESHOLD: thr = val[THR_W-1:0];
        REG_CLASS_AGNOSTIC: agnostic = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function void report_mismatch(string msg);
      errors++;
      $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function void note_box(box_t bx);
      int       l, t, r, b;
      int       il, it, ir, ib;
      u64_t     area, inter, uni;
      bit       survive;
      verdict_t v;
      l = $signed(bx.l);
      t = $signed(bx.t);
      r = $signed(bx.r);
      b = $signed(bx.b);
      area = extent(l, r) * extent(t, b);
      if (bx.first) begin
        kept_n  = 0;
        set_pos = 0;
      end
      v.ordinal = ORD_W'(set_pos);
      set_pos = (set_pos + 1) % MAX_SET_DEF;
      survive = 1'b1;
      for (int i = 0; i < kept_n; i++) begin
        if (!agnostic && klab[i] != bx.label) continue;
        il = (l > kl[i]) ? l : kl[i];
        it = (t > kt[i]) ? t : kt[i];
        ir = (r < kr[i]) ? r : kr[i];
        ib = (b < kb[i]) ? b : kb[i];
        inter = extent(il, ir) * extent(it, ib);
        uni = area + karea[i] - inter;
        if ((inter << 16) > u64_t'(thr) * uni) begin
          survive = 1'b0;
          break;
        end
      end
      v.keep = 1'b0;
      v.full = 1'b0;
      if (survive) begin
        if (kept_n < MAX_KEPT_DEF) begin
          kl[kept_n]    = l;
          kt[kept_n]    = t;
          kr[kept_n]    = r;
          kb[kept_n]    = b;
          klab[kept_n]  = bx.label;
          karea[kept_n] = area;
          kept_n++;
          v.keep = 1'b1;
        end else begin
          v.full = 1'b1;
        end
      end
      verdicts.insert(verdicts.size(), v);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (verdicts.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: keep=%0b ordinal=%0d full=%0b",
                                  got.keep, got.ordinal, got.full));
        return;
      end
      want = verdicts.pop_front();
      if (got.keep !== want.keep)
        report_mismatch($sformatf("ordinal %0d: keep %0b, want %0b",
                                  want.ordinal, got.keep, want.keep));
      if (got.ordinal !== want.ordinal)
        report_mismatch($sformatf("box_ordinal %0d, want %0d", got.ordinal, want.ordinal));
      if (got.full !== want.full)
        report_mismatch($sformatf("ordinal %0d: list_full %0b, want %0b",
                                  want.ordinal, got.full, want.full));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  bit   want_hold;
  int   random_sent;

  keep_tracker nms = new();

  gbs_box_if box_ch ();
  gbs_res_if res_ch ();
  gbs_cfg_if cfg_ch ();

  greedy_box_suppression_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_box (box_ch),
    .out_res(res_ch),
    .cfg_wr (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic box_t mk_box(int l, int t, int r, int b, logic [LABEL_W-1:0] lab,
                                  bit first);
    box_t bx;
    bx.l     = COORD_W'(l);
    bx.t     = COORD_W'(t);
    bx.r     = COORD_W'(r);
    bx.b     = COORD_W'(b);
    bx.label = lab;
    bx.first = first;
    return bx;
  endfunction

  function automatic int wobble(int a);
    return int'($urandom_range(2 * a)) - a;
  endfunction

  function automatic box_t cluster_box(int cx, int cy, int hw, int hh,
                                       logic [LABEL_W-1:0] lab, bit exact);
    int jx, jy;
    jx = exact ? 0 : hw / 3;
    jy = exact ? 0 : hh / 3;
    return mk_box(cx - hw + wobble(jx), cy - hh + wobble(jy),
                  cx + hw + wobble(jx), cy + hh + wobble(jy), lab, 1'b0);
  endfunction

  function automatic box_t noise_box();
    return mk_box($urandom, $urandom, $urandom, $urandom,
                  LABEL_W'($urandom_range(255)), 1'b0);
  endfunction

  task automatic send_box(box_t bx);
    while (!calm && $urandom_range(99) < 15) begin
      box_ch.valid <= 1'b0;
      @(posedge clk);
    end
    box_ch.valid        <= 1'b1;
    box_ch.left_edge    <= bx.l;
    box_ch.top_edge     <= bx.t;
    box_ch.right_edge   <= bx.r;
    box_ch.bottom_edge  <= bx.b;
    box_ch.class_label  <= bx.label;
    box_ch.first_of_set <= bx.first;
    do @(posedge clk); while (!box_ch.ready);
    nms.note_box(bx);
  endtask

  task automatic wait_all_verdicts();
    box_ch.valid <= 1'b0;
    do @(posedge clk); while (nms.pending() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    nms.set_reg(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_directed();
    // reset config, no first_of_set on the very first box
    send_box(mk_box(0, 0, 160, 160, 3, 0));
    send_box(mk_box(0, 0, 160, 160, 3, 0));
    send_box(mk_box(0, 0, 160, 160, 4, 0));
    send_box(mk_box(160, 0, 0, 160, 3, 0));
    send_box(mk_box(160, 0, 0, 160, 3, 0));
    send_box(mk_box(-32768, -32768, 32767, 32767, 255, 0));
    send_box(mk_box(-32768, -32768, 32767, 32767, 255, 0));
    send_box(mk_box(-32768, -32768, -32768, -32768, 255, 0));
    send_box(mk_box(32767, 32767, 32767, 32767, 0, 0));
    send_box(mk_box(0, 0, 160, 150, 3, 0));
    send_box(mk_box(80, 0, 240, 160, 3, 0));
    wait_all_verdicts();
    write_reg(REG_IOU_THRESHOLD, '0);
    write_reg(REG_CLASS_AGNOSTIC, CFG_DAT_W'(1));
    write_reg(REG_SPARE_LO, CFG_DAT_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_DAT_W'($urandom));
    send_box(mk_box(0, 0, 320, 320, 9, 1));
    send_box(mk_box(319, 319, 640, 640, 10, 0));
    send_box(mk_box(320, 320, 640, 640, 11, 0));
    wait_all_verdicts();
    write_reg(REG_IOU_THRESHOLD, '1);
    write_reg(REG_CLASS_AGNOSTIC, CFG_DAT_W'(16'hFFFE));
    send_box(mk_box(-1000, -1000, 1000, 1000, 200, 1));
    send_box(mk_box(-1000, -1000, 1000, 1000, 200, 0));
    send_box(mk_box(-1000, -1000, 1000, 999, 200, 0));
    send_box(mk_box(-1000, -1000, 1000, 1000, 201, 0));
  endtask

  // disjoint grid overruns the kept list; a few repeats of the first box get suppressed
  task automatic fill_list();
    int   k;
    box_t bx;
    wait_all_verdicts();
    write_reg(REG_IOU_THRESHOLD, IOU_THR_RESET);
    write_reg(REG_CLASS_AGNOSTIC, CFG_DAT_W'(1));
    for (k = 0; k < FILL_ITEMS; k++) begin
      if (k > MAX_KEPT_DEF && k % 20 == 10)
        bx = mk_box(0, 0, 32, 32, 5, 0);
      else
        bx = mk_box((k % 20) * 64, (k / 20) * 64, (k % 20) * 64 + 32, (k / 20) * 64 + 32,
                    LABEL_W'(k * 37), k == 0);
      send_box(bx);
    end
  endtask

  task automatic run_set(int len, bit fresh);
    int                 cx[4], cy[4], hw[4], hh[4];
    logic [LABEL_W-1:0] lab[4];
    int                 n, c, k, roll;
    box_t               bx;
    n = $urandom_range(1, 4);
    for (k = 0; k < 4; k++) begin
      cx[k]  = int'($urandom_range(48000)) - 24000;
      cy[k]  = int'($urandom_range(48000)) - 24000;
      hw[k]  = $urandom_range(8, 3000);
      hh[k]  = $urandom_range(8, 3000);
      lab[k] = (k > 0 && $urandom_range(1)) ? lab[0] : LABEL_W'($urandom_range(255));
    end
    for (k = 0; k < len; k++) begin
      c    = $urandom_range(n - 1);
      roll = $urandom_range(99);
      if (roll < 15) begin
        bx = cluster_box(cx[c], cy[c], hw[c], hh[c], lab[c], 1'b1);
      end else if (roll < 85) begin
        bx = cluster_box(cx[c], cy[c], hw[c], hh[c], lab[c], 1'b0);
      end else if (roll < 95) begin
        bx = noise_box();
      end else begin
        bx = cluster_box(cx[c], cy[c], hw[c], hh[c], lab[c], 1'b0);
        {bx.l, bx.r} = {bx.r, bx.l};
      end
      bx.first = (k == 0) ? fresh : ($urandom_range(49) == 0);
      send_box(bx);
      random_sent++;
    end
  endtask

  task automatic run_phase(int phase);
    logic [CFG_DAT_W-1:0] thr_val;
    int                   sets, k, len;
    wait_all_verdicts();
    case ($urandom_range(5))
      0: thr_val = '0;
      1: thr_val = '1;
      2: thr_val = IOU_THR_RESET;
      default: thr_val = CFG_DAT_W'($urandom_range(65535));
    endcase
    write_reg(REG_IOU_THRESHOLD, thr_val);
    write_reg(REG_CLASS_AGNOSTIC, ($urandom_range(3) == 0) ? CFG_DAT_W'($urandom)
                                                             : CFG_DAT_W'($urandom_range(1)));
    if ($urandom_range(7) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DAT_W'($urandom));
    calm <= (phase == 1);
    sets = (phase == 3) ? 3 : $urandom_range(1, 4);
    for (k = 0; k < sets; k++) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      if (phase == 2 && k == 0) begin
        want_hold <= 1'b1;
        len = 60;
      end
      if (phase == 3 && k > 0) wait_all_verdicts();
      run_set(len, $urandom_range(19) != 0);
      if (phase == 2 && k == 0) want_hold <= 1'b0;
    end
  endtask

  initial begin : result_side
    int hold_left;
    bit hold_seen;
    verdict_t got;
    hold_left = 0;
    hold_seen = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        got.keep    = res_ch.keep;
        got.ordinal = res_ch.box_ordinal;
        got.full    = res_ch.list_full;
        nms.check_verdict(got);
      end
      if (want_hold && !hold_seen) hold_left = HOLD_CYCLES;
      hold_seen = want_hold;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= calm || ($urandom_range(99) >= 15);
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int phase;
    rst_n               <= 1'b0;
    calm                <= 1'b0;
    want_hold           <= 1'b0;
    box_ch.valid        <= 1'b0;
    box_ch.left_edge    <= '0;
    box_ch.top_edge     <= '0;
    box_ch.right_edge   <= '0;
    box_ch.bottom_edge  <= '0;
    box_ch.class_label  <= '0;
    box_ch.first_of_set <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= '0;
    cfg_ch.data         <= '0;
    random_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    fill_list();
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      run_phase(phase);
      phase++;
    end
    wait_all_verdicts();
    repeat (MAX_KEPT_DEF + 20) @(posedge clk);
    if (nms.pending() != 0)
      nms.report_mismatch($sformatf("%0d results never arrived", nms.pending()));
    if (nms.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/gbs_pkg.sv
rtl/gbs_box_if.sv
rtl/gbs_res_if.sv
rtl/gbs_cfg_if.sv
rtl/greedy_box_suppression_core.sv
tb/greedy_box_suppression_core_tb.sv
